>>> hw/rtl/bss_pkg.sv
package bss_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_BADPOS    = 3'd3,
        ST_NOTFOUND  = 3'd4
    } status_t;

    // push: every cell takes its neighbor toward the top (cell 0 takes the new word)
    // shift: every cell takes its neighbor toward the bottom; the last held cell wraps
    typedef struct packed {
        logic push;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/bounded_stack_with_search_core.sv
// Bounded LIFO stack with search.
// Commands: assert start with cmd/value/position; the command is taken on a
// clock edge where start is high and busy is low. Commands are push, pop,
// read at 1-based position from the bottom, and search for a value.
// Each command returns one result, shown for exactly one cycle with done
// high: data, found_position, status, count, empty_res, full_res.
// The receiver cannot stall; results must be taken when done is high.
// Entries live in a row of cells with the top of stack in cell 0.
// Push, pop, a read at a bad position and a search on an empty stack
// finish without a scan: done follows in the next cycle, busy stays low.
// A valid read and a search on a non-empty stack rotate the held entries
// through cell 0, one cell per cycle; busy is high while they rotate and
// done is registered after the last step. Rotation leaves the order.
// Capacity is written on the cfg channel (cfg_valid/cfg_ready) while idle;
// values above DEPTH act as DEPTH.
// Reset (rst_n low, async) empties the stack and sets capacity to 16.
module bounded_stack_with_search_core
    import bss_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] value,
    input  logic [4:0]  position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output logic        done,
    output logic [15:0] data,
    output logic [4:0]  found_position,
    output logic [2:0]  status,
    output logic [4:0]  count,
    output logic        empty_res,
    output logic        full_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         step_reg, step_next;
    logic [CW-1:0]         target_reg, target_next;
    logic [4:0]            capacity_reg, capacity_next;
    logic                  done_reg, done_next;
    logic                  full_reg, full_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [15:0]           data_reg, data_next;
    logic [4:0]            found_reg, found_next;
    status_t               status_reg, status_next;

    logic                  accept;
    cmd_t                  cmd_in;
    logic [DATA_WIDTH-1:0] value_w;
    logic [MW-1:0]         cap_eff;
    logic [MW-1:0]         count_ext;
    logic                  can_push;
    logic                  pos_ok;
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] words [DEPTH];

    assign busy      = (state_reg == S_SCAN);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign cmd_in    = cmd_t'(cmd);
    assign value_w   = DATA_WIDTH'(value);

    assign count_ext = MW'(count_reg);
    assign cap_eff   = (MW'(capacity_reg) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(capacity_reg);
    assign can_push  = count_ext < cap_eff;
    assign pos_ok    = (position != 5'd0) && (MW'(position) <= count_ext);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] up_w;
            logic [DATA_WIDTH-1:0] down_w;

            if (gi == 0)
            begin : g_first
                assign up_w = value_w;
            end
            else
            begin : g_mid_up
                assign up_w = words[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_final
                assign down_w = '0;
            end
            else
            begin : g_mid_down
                assign down_w = words[gi+1];
            end

            bss_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .is_last   (count_reg == CW'(gi + 1)),
                .up_word   (up_w),
                .down_word (down_w),
                .wrap_word (words[0]),
                .word      (words[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        target_next   = target_reg;
        capacity_next = capacity_reg;
        done_next     = 1'b0;
        full_next     = full_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        data_next     = data_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        ctrl          = '0;

        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd_in;
                    value_next  = value_w;
                    data_next   = '0;
                    found_next  = '0;
                    status_next = ST_OK;
                    step_next   = '0;
                    target_next = CW'(count_ext - MW'(position));
                    unique case (cmd_in)
                        CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (can_push)
                            begin
                                ctrl.push  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_OVERFLOW;
                            end
                        end
                        CMD_POP:
                        begin
                            done_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                ctrl.shift = 1'b1;
                                count_next = count_reg - 1'b1;
                                data_next  = 16'(words[0]);
                            end
                            else
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADPOS;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            status_next = ST_NOTFOUND;
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                    full_next = (MW'(count_next) >= cap_eff);
                end
            end
            S_SCAN:
            begin
                // cell 0 holds the entry step_reg places below the top
                ctrl.shift = 1'b1;
                step_next  = step_reg + 1'b1;
                if (cmd_reg == CMD_SEARCH && words[0] == value_reg)
                begin
                    found_next  = 5'(count_reg - step_reg);
                    status_next = ST_OK;
                end
                if (cmd_reg == CMD_READ && step_reg == target_reg)
                begin
                    data_next = 16'(words[0]);
                end
                if (step_reg == count_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            capacity_reg <= 5'd16;
            done_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
            done_reg     <= done_next;
            full_reg     <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        target_reg <= target_next;
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign done           = done_reg;
    assign data           = data_reg;
    assign found_position = found_reg;
    assign status         = status_reg;
    assign count          = 5'(count_reg);
    assign empty_res      = (count_reg == '0);
    assign full_res       = full_reg;

endmodule

>>> hw/rtl/bss_cell.sv
module bss_cell
    import bss_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic                  is_last,
    input  logic [DATA_WIDTH-1:0] up_word,
    input  logic [DATA_WIDTH-1:0] down_word,
    input  logic [DATA_WIDTH-1:0] wrap_word,
    output logic [DATA_WIDTH-1:0] word
);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        priority if (ctrl.push)
        begin
            word_next = up_word;
        end
        else if (ctrl.shift)
        begin
            word_next = is_last ? wrap_word : down_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

>>> sim/bounded_stack_with_search_core_tb.sv
`timescale 1ns / 1ps

module bounded_stack_with_search_core_tb;
    import bss_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 128;

    typedef struct {
        logic [15:0] data;
        logic [4:0]  hit_pos;
        status_t     status;
        logic [4:0]  count;
        logic        empty_f;
        logic        full_f;
    } result_t;

    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg_val;
        cmd_t        cmd;
        logic [15:0] value;
        logic [4:0]  pos;
        bit          pinned;
        result_t     res;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [15:0] value;
    logic [4:0]  position;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        done;
    logic [15:0] data;
    logic [4:0]  found_position;
    logic [2:0]  status;
    logic [4:0]  count;
    logic        empty_res;
    logic        full_res;

    // shadow copy of the stack
    logic [15:0] shadow_words [DEPTH];
    int          shadow_fill;
    logic [4:0]  shadow_cap;

    result_t     pending_results [$];
    plan_row_t   plan [$];
    int          phase_caps [12] = '{16, 31, 4, 1, 0, 17, 9, 16, 2, 31, 12, 16};

    bit          pin_now;
    result_t     pin_res;
    int          mismatch_count;
    int          quiet_cycles;
    bit          moved;
    result_t     next_exp;

    bounded_stack_with_search_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .value          (value),
        .position       (position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .data           (data),
        .found_position (found_position),
        .status         (status),
        .count          (count),
        .empty_res      (empty_res),
        .full_res       (full_res)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t stack_step(cmd_t c, logic [15:0] v, logic [4:0] p);
        result_t r;
        int      cap;
        cap = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
        r.data    = '0;
        r.hit_pos = '0;
        r.status  = ST_OK;
        case (c)
            CMD_PUSH:
            begin
                if (shadow_fill >= cap)
                    r.status = ST_OVERFLOW;
                else
                begin
                    shadow_words[shadow_fill] = v;
                    shadow_fill++;
                end
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    shadow_fill--;
                    r.data = shadow_words[shadow_fill];
                end
            end
            CMD_READ:
            begin
                if (p < 1 || int'(p) > shadow_fill)
                    r.status = ST_BADPOS;
                else
                    r.data = shadow_words[p - 1];
            end
            default:
            begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (r.hit_pos == 0 && shadow_words[i] == v)
                    begin
                        r.hit_pos = 5'(i + 1);
                        r.status  = ST_OK;
                    end
                end
            end
        endcase
        r.count   = 5'(shadow_fill);
        r.empty_f = (shadow_fill == 0);
        r.full_f  = (shadow_fill >= cap);
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result();
        result_t e;
        if (pending_results.size() == 0)
        begin
            note_mismatch($sformatf("result with no pending command (data %h status %0d)",
                                    data, status));
            return;
        end
        e = pending_results.pop_front();
        compare_field("data", data, e.data);
        compare_field("found_position", 16'(found_position), 16'(e.hit_pos));
        compare_field("status", 16'(status), 16'(e.status));
        compare_field("count", 16'(count), 16'(e.count));
        compare_field("empty_res", 16'(empty_res), 16'(e.empty_f));
        compare_field("full_res", 16'(full_res), 16'(e.full_f));
    endtask

    // monitor: results, transfers, capacity writes, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                check_result();
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                next_exp = stack_step(cmd_t'(cmd), value, position);
                if (pin_now)
                    next_exp = pin_res;
                pending_results.push_back(next_exp);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                shadow_cap = cfg_data;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        else if (k < 90)
            return $urandom_range(1, 3);
        else if (k < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_cmd(cmd_t c, logic [15:0] v, logic [4:0] p, bit pinned, result_t res);
        @(negedge clk);
        start    <= 1'b1;
        cmd      <= c;
        value    <= v;
        position <= p;
        pin_now  = pinned;
        pin_res  = res;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start    <= 1'b0;
            cmd      <= 2'($urandom_range(0, 3));
            value    <= 16'($urandom);
            position <= 5'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= 5'($urandom);
    endtask

    task automatic random_item(int push_weight);
        int          k;
        cmd_t        c;
        logic [15:0] v;
        logic [4:0]  p;
        result_t     unused;
        k = $urandom_range(0, 99);
        if (k < push_weight)
            c = CMD_PUSH;
        else if (k % 3 == 0)
            c = CMD_POP;
        else if (k % 3 == 1)
            c = CMD_READ;
        else
            c = CMD_SEARCH;
        k = $urandom_range(0, 9);
        if (k < 4 && shadow_fill > 0)
            v = shadow_words[$urandom_range(0, shadow_fill - 1)];
        else if (k < 6)
            v = 16'($urandom_range(0, 7));
        else if (k == 6)
            v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            v = 16'($urandom);
        k = $urandom_range(0, 9);
        if (k < 7)
            p = 5'($urandom_range(1, (shadow_fill == 0) ? 1 : shadow_fill));
        else if (k == 7)
            p = 5'd0;
        else if (k == 8)
            p = 5'(shadow_fill + 1);
        else
            p = 5'($urandom);
        unused = '{default: '0, status: ST_OK};
        send_cmd(c, v, p, 1'b0, unused);
    endtask

    function automatic void add_cfg(logic [4:0] v);
        plan_row_t r;
        r = '{default: '0, cmd: CMD_PUSH, res: '{default: '0, status: ST_OK}};
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        plan.push_back(r);
    endfunction

    function automatic void add_cmd(cmd_t c, logic [15:0] v, logic [4:0] p);
        plan_row_t r;
        r = '{default: '0, cmd: CMD_PUSH, res: '{default: '0, status: ST_OK}};
        r.cmd   = c;
        r.value = v;
        r.pos   = p;
        plan.push_back(r);
    endfunction

    function automatic void add_pin(cmd_t c, logic [15:0] v, logic [4:0] p,
                                    logic [15:0] d, logic [4:0] hp, status_t st,
                                    logic [4:0] cnt, logic e, logic f);
        plan_row_t r;
        r = '{default: '0, cmd: CMD_PUSH, res: '{default: '0, status: ST_OK}};
        r.cmd         = c;
        r.value       = v;
        r.pos         = p;
        r.pinned      = 1'b1;
        r.res.data    = d;
        r.res.hit_pos = hp;
        r.res.status  = st;
        r.res.count   = cnt;
        r.res.empty_f = e;
        r.res.full_f  = f;
        plan.push_back(r);
    endfunction

    initial
    begin
        int pw;
        bit calm;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_PUSH;
        value          = '0;
        position       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        pin_now        = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        shadow_fill    = 0;
        shadow_cap     = 5'd16;
        foreach (shadow_words[i])
            shadow_words[i] = '0;

        // after reset: empty, capacity 16
        add_pin(CMD_POP,    16'h0000, 5'd0,  16'h0000, 5'd0, ST_UNDERFLOW, 5'd0, 1, 0);
        add_pin(CMD_READ,   16'h0000, 5'd0,  16'h0000, 5'd0, ST_BADPOS,    5'd0, 1, 0);
        add_pin(CMD_SEARCH, 16'h0000, 5'd0,  16'h0000, 5'd0, ST_NOTFOUND,  5'd0, 1, 0);
        add_pin(CMD_PUSH,   16'hFFFF, 5'd31, 16'h0000, 5'd0, ST_OK,        5'd1, 0, 0);
        add_pin(CMD_PUSH,   16'h0000, 5'd0,  16'h0000, 5'd0, ST_OK,        5'd2, 0, 0);
        add_pin(CMD_READ,   16'h1234, 5'd1,  16'hFFFF, 5'd0, ST_OK,        5'd2, 0, 0);
        add_pin(CMD_READ,   16'h0000, 5'd2,  16'h0000, 5'd0, ST_OK,        5'd2, 0, 0);
        add_pin(CMD_READ,   16'h0000, 5'd3,  16'h0000, 5'd0, ST_BADPOS,    5'd2, 0, 0);
        add_pin(CMD_READ,   16'hFFFF, 5'd31, 16'h0000, 5'd0, ST_BADPOS,    5'd2, 0, 0);
        add_pin(CMD_SEARCH, 16'h0000, 5'd0,  16'h0000, 5'd2, ST_OK,        5'd2, 0, 0);
        add_pin(CMD_SEARCH, 16'hFFFF, 5'd0,  16'h0000, 5'd1, ST_OK,        5'd2, 0, 0);
        add_pin(CMD_SEARCH, 16'h1234, 5'd0,  16'h0000, 5'd0, ST_NOTFOUND,  5'd2, 0, 0);
        add_cmd(CMD_PUSH,   16'hFFFF, 5'd0);
        add_cmd(CMD_SEARCH, 16'hFFFF, 5'd0);
        add_cmd(CMD_POP,    16'h0000, 5'd0);
        add_cmd(CMD_POP,    16'h0000, 5'd0);
        // capacity at count: full and overflow
        add_cfg(5'd2);
        add_pin(CMD_PUSH,   16'hA5A5, 5'd0,  16'h0000, 5'd0, ST_OK,        5'd2, 0, 1);
        add_pin(CMD_PUSH,   16'h5A5A, 5'd0,  16'h0000, 5'd0, ST_OVERFLOW,  5'd2, 0, 1);
        // capacity lowered below count
        add_cfg(5'd1);
        add_pin(CMD_PUSH,   16'h5A5A, 5'd0,  16'h0000, 5'd0, ST_OVERFLOW,  5'd2, 0, 1);
        add_cmd(CMD_READ,   16'h0000, 5'd2);
        add_pin(CMD_POP,    16'h0000, 5'd0,  16'hA5A5, 5'd0, ST_OK,        5'd1, 0, 1);
        // capacity zero: empty and full at once
        add_cfg(5'd0);
        add_pin(CMD_PUSH,   16'h8001, 5'd0,  16'h0000, 5'd0, ST_OVERFLOW,  5'd1, 0, 1);
        add_pin(CMD_POP,    16'h0000, 5'd0,  16'hFFFF, 5'd0, ST_OK,        5'd0, 1, 1);
        add_pin(CMD_PUSH,   16'h8001, 5'd0,  16'h0000, 5'd0, ST_OVERFLOW,  5'd0, 1, 1);
        add_pin(CMD_SEARCH, 16'h0000, 5'd0,  16'h0000, 5'd0, ST_NOTFOUND,  5'd0, 1, 1);
        // capacity above depth
        add_cfg(5'd31);
        add_cmd(CMD_PUSH,   16'h7FFF, 5'd0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_capacity(plan[i].cfg_val);
            else
            begin
                send_cmd(plan[i].cmd, plan[i].value, plan[i].pos, plan[i].pinned, plan[i].res);
                pause_sender(pick_gap());
            end
        end

        foreach (phase_caps[ph])
        begin
            write_capacity(5'(phase_caps[ph]));
            pw   = $urandom_range(25, 60);
            calm = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                random_item(pw);
                if (!calm)
                    pause_sender(pick_gap());
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
